### sv/wet_pkg.sv
// Package: sizes, codes, types and control/status structs of the weighted edge table.
`timescale 1ns / 1ps

package wet_pkg;

	localparam int NODES       = 32;
	localparam int NODE_W      = 5;
	localparam int WEIGHT_BITS = 24;
	localparam int FRAC_BITS   = 8;
	localparam int MEM_DEPTH   = NODES * NODES;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	localparam logic [WEIGHT_BITS-1:0] ONE_WEIGHT = WEIGHT_BITS'(1 << FRAC_BITS);

	// opcodes
	localparam logic [2:0] OP_INC    = 3'd0;
	localparam logic [2:0] OP_DEC    = 3'd1;
	localparam logic [2:0] OP_QUERY  = 3'd2;
	localparam logic [2:0] OP_SET    = 3'd3;
	localparam logic [2:0] OP_RMNODE = 3'd4;
	localparam logic [2:0] OP_LIST   = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_SAME    = 2'd2;

	typedef struct packed {
		logic                   present;
		logic [WEIGHT_BITS-1:0] weight;
	} word_t;

	typedef struct packed {
		logic [1:0]             status;
		logic                   removed;
		logic                   exists;
		logic [WEIGHT_BITS-1:0] weight;
		logic [NODE_W-1:0]      neighbor;
		logic                   neighbor_valid;
		logic                   last;
	} result_t;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DISP, S_RD, S_CHK, S_WR1, S_WR2,
		S_RM1, S_RM2, S_LRD, S_LCK, S_LDEC, S_LEND, S_RSP
	} state_t;

	typedef enum logic [2:0] {
		A_AB, A_BA, A_AN, A_NA, A_CNT
	} asel_t;

	typedef enum logic [1:0] {
		O_RESP, O_PEND_MID, O_PEND_END
	} osel_t;

	typedef struct packed {
		logic  item_load;
		logic  chk;
		logic  cnt_clr;
		logic  cnt_inc;
		asel_t asel;
		logic  mem_we;
		logic  wzero;
		logic  lck;
		logic  pend_clr;
		logic  pend_load;
		logic  out_ld;
		osel_t osel;
	} ctl_cmd_t;

	typedef struct packed {
		logic resp_only;
		logic is_rm;
		logic is_list;
		logic wr_needed;
		logic cnt_last;
		logic clr_last;
		logic hit;
		logic pend_v;
		logic out_busy;
	} dp_stat_t;

endpackage

### sv/wet_req_if.sv
// Interface: input item channel with valid/ready handshake.
`timescale 1ns / 1ps

interface wet_req_if import wet_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [2:0]             opcode;
	logic [NODE_W-1:0]      node_a;
	logic [NODE_W-1:0]      node_b;
	logic [WEIGHT_BITS-1:0] amount;
	logic                   include_self;

	modport source (output valid, opcode, node_a, node_b, amount, include_self, input ready);
	modport sink (input valid, opcode, node_a, node_b, amount, include_self, output ready);
endinterface

### sv/wet_rsp_if.sv
// Interface: result item channel with valid/ready handshake.
`timescale 1ns / 1ps

interface wet_rsp_if import wet_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic                   removed;
	logic                   exists;
	logic [WEIGHT_BITS-1:0] weight;
	logic [NODE_W-1:0]      neighbor;
	logic                   neighbor_valid;
	logic                   last;

	modport source (output valid, status, removed, exists, weight, neighbor,
		neighbor_valid, last, input ready);
	modport sink (input valid, status, removed, exists, weight, neighbor,
		neighbor_valid, last, output ready);
endinterface

### sv/wet_datapath.sv
// Datapath: edge memory, item and result registers, update arithmetic, list candidate logic.
`timescale 1ns / 1ps

module wet_datapath import wet_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  ctl_cmd_t               cmd,
	output dp_stat_t               stat,
	input  logic [2:0]             opcode,
	input  logic [NODE_W-1:0]      node_a,
	input  logic [NODE_W-1:0]      node_b,
	input  logic [WEIGHT_BITS-1:0] amount,
	input  logic                   include_self,
	input  logic                   rsp_ready,
	output logic                   out_valid,
	output result_t                out_res
);

	word_t                  mem [MEM_DEPTH];
	word_t                  rdata_q;
	word_t                  new_q;
	word_t                  wdata;
	logic [ADDR_W-1:0]      addr;
	logic [ADDR_W-1:0]      cnt_q;
	logic [NODE_W-1:0]      n;

	logic [2:0]             op_q;
	logic [NODE_W-1:0]      a_q, b_q;
	logic [WEIGHT_BITS-1:0] amt_q;
	logic                   self_q;

	result_t                resp_q, resp_chk, cand, cand_q, pend_q;
	result_t                resp_ld, pend_end;
	logic                   pend_v_q, hit_q, out_v_q, hit_c;
	word_t                  new_c;
	logic                   wr_c;
	logic [WEIGHT_BITS:0]   sum;
	logic [WEIGHT_BITS-1:0] base;

	assign n = cnt_q[NODE_W-1:0];

	// address select; NODES is a power of two, so row-major index is a concatenation
	always_comb begin
		case (cmd.asel)
			A_AB:    addr = {a_q, b_q};
			A_BA:    addr = {b_q, a_q};
			A_AN:    addr = {a_q, n};
			A_NA:    addr = {n, a_q};
			A_CNT:   addr = cnt_q;
			default: addr = cnt_q;
		endcase
	end

	assign wdata = cmd.wzero ? word_t'('0) : new_q;

	// edge memory: one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	// sweep counter for clear, remove and list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + ADDR_W'(1);
		end
	end

	// default response of an incoming item
	always_comb begin
		resp_ld = '0;
		resp_ld.last = 1'b1;
		if (opcode <= OP_SET && node_a == node_b) begin
			resp_ld.status = ST_SAME;
		end
	end

	// hold the accepted item and its default response; on check, the checked response and new word
	always_ff @(posedge clk) begin
		if (cmd.item_load) begin
			op_q   <= opcode;
			a_q    <= node_a;
			b_q    <= node_b;
			amt_q  <= amount;
			self_q <= include_self;
			resp_q <= resp_ld;
		end else if (cmd.chk) begin
			resp_q <= resp_chk;
			new_q  <= new_c;
		end
	end

	// read-modify-write arithmetic on the addressed edge
	always_comb begin
		base = rdata_q.present ? rdata_q.weight : '0;
		sum  = {1'b0, base} + {1'b0, amt_q};
		resp_chk = '0;
		resp_chk.last = 1'b1;
		new_c = '0;
		wr_c  = 1'b0;
		case (op_q)
			OP_INC: begin
				new_c.present = 1'b1;
				new_c.weight  = sum[WEIGHT_BITS] ? '1 : sum[WEIGHT_BITS-1:0];
				wr_c = 1'b1;
			end
			OP_DEC: begin
				if (!rdata_q.present) begin
					resp_chk.status = ST_MISSING;
				end else if (rdata_q.weight > ONE_WEIGHT) begin
					new_c.present = 1'b1;
					new_c.weight  = rdata_q.weight - ONE_WEIGHT;
					wr_c = 1'b1;
				end else begin
					resp_chk.removed = 1'b1;
					wr_c = 1'b1;
				end
			end
			OP_QUERY: begin
				resp_chk.exists = rdata_q.present;
				resp_chk.weight = base;
			end
			OP_SET: begin
				new_c.present = 1'b1;
				new_c.weight  = amt_q;
				wr_c = 1'b1;
			end
			default: begin
				wr_c = 1'b0;
			end
		endcase
	end

	// list candidate for node n
	always_comb begin
		cand = '0;
		cand.neighbor = n;
		cand.neighbor_valid = 1'b1;
		if (n == a_q) begin
			hit_c = self_q;
		end else begin
			hit_c = rdata_q.present && (rdata_q.weight >= amt_q);
			cand.weight = rdata_q.weight;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lck) begin
			cand_q <= cand;
		end
		if (cmd.pend_load) begin
			pend_q <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd.lck) begin
				hit_q <= hit_c;
			end
			if (cmd.pend_clr) begin
				pend_v_q <= 1'b0;
			end else if (cmd.pend_load) begin
				pend_v_q <= 1'b1;
			end
		end
	end

	// final list result: held node or empty marker, always last
	always_comb begin
		pend_end = pend_v_q ? pend_q : result_t'('0);
		pend_end.last = 1'b1;
	end

	// output register: load on command, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_v_q <= 1'b1;
		end else if (rsp_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			case (cmd.osel)
				O_RESP: begin
					out_res <= resp_q;
				end
				O_PEND_MID: begin
					out_res <= pend_q;
				end
				O_PEND_END: begin
					out_res <= pend_end;
				end
				default: begin
					out_res <= resp_q;
				end
			endcase
		end
	end

	assign out_valid = out_v_q;

	assign stat.resp_only = (op_q <= OP_SET && a_q == b_q) || (op_q > OP_LIST);
	assign stat.is_rm     = (op_q == OP_RMNODE);
	assign stat.is_list   = (op_q == OP_LIST);
	assign stat.wr_needed = wr_c;
	assign stat.cnt_last  = (n == NODE_W'(NODES - 1));
	assign stat.clr_last  = (cnt_q == ADDR_W'(MEM_DEPTH - 1));
	assign stat.hit       = hit_q;
	assign stat.pend_v    = pend_v_q;
	assign stat.out_busy  = out_v_q && !rsp_ready;

endmodule

### sv/wet_ctrl.sv
// Controller: state machine sequencing clear, updates, node removal and neighbor listing.
`timescale 1ns / 1ps

module wet_ctrl import wet_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd,
	output state_t   state
);

	state_t state_q, state_d;
	logic   adv;

	assign state = state_q;
	assign adv = !stat.hit || !stat.pend_v || !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) state_d = S_DISP;
			end
			S_DISP: begin
				if (stat.resp_only) state_d = S_RSP;
				else if (stat.is_rm) state_d = S_RM1;
				else if (stat.is_list) state_d = S_LRD;
				else state_d = S_RD;
			end
			S_RD:  state_d = S_CHK;
			S_CHK: state_d = stat.wr_needed ? S_WR1 : S_RSP;
			S_WR1: state_d = S_WR2;
			S_WR2: state_d = S_RSP;
			S_RM1: state_d = S_RM2;
			S_RM2: state_d = stat.cnt_last ? S_RSP : S_RM1;
			S_LRD: state_d = S_LCK;
			S_LCK: state_d = S_LDEC;
			S_LDEC: begin
				if (adv) state_d = stat.cnt_last ? S_LEND : S_LRD;
			end
			S_LEND: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			S_RSP: begin
				if (!stat.out_busy) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.asel = A_CNT;
		cmd.osel = O_RESP;
		req_ready = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.mem_we  = 1'b1;
				cmd.wzero   = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_IDLE: begin
				req_ready = 1'b1;
				cmd.item_load = req_valid;
			end
			S_DISP: begin
				cmd.cnt_clr  = 1'b1;
				cmd.pend_clr = 1'b1;
			end
			S_RD: cmd.asel = A_AB;
			S_CHK: cmd.chk = 1'b1;
			S_WR1: begin
				cmd.asel   = A_AB;
				cmd.mem_we = 1'b1;
			end
			S_WR2: begin
				cmd.asel   = A_BA;
				cmd.mem_we = 1'b1;
			end
			S_RM1: begin
				cmd.asel   = A_AN;
				cmd.mem_we = 1'b1;
				cmd.wzero  = 1'b1;
			end
			S_RM2: begin
				cmd.asel    = A_NA;
				cmd.mem_we  = 1'b1;
				cmd.wzero   = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			S_LRD: cmd.asel = A_AN;
			S_LCK: cmd.lck = 1'b1;
			S_LDEC: begin
				if (adv) begin
					cmd.cnt_inc   = 1'b1;
					cmd.pend_load = stat.hit;
					cmd.out_ld    = stat.hit && stat.pend_v;
					cmd.osel      = O_PEND_MID;
				end
			end
			S_LEND: begin
				cmd.out_ld = !stat.out_busy;
				cmd.osel   = O_PEND_END;
			end
			S_RSP: begin
				cmd.out_ld = !stat.out_busy;
				cmd.osel   = O_RESP;
			end
			default: begin
				cmd.asel = A_CNT;
			end
		endcase
	end

endmodule

### sv/weighted_edge_table.sv
// Top level: weighted edge table, controller and datapath with channel interfaces.
`timescale 1ns / 1ps

// Symmetric weighted edge table over 32 nodes, weights unsigned Q16.8 with saturating sums.
// After reset the block sweeps the 1024-entry edge memory once, one entry per cycle,
// and accepts no item until that is done. Items are handled one at a time through a
// single-port memory: increase, set and decrease pass accept, dispatch, read, check,
// two mirrored writes and response; query and a decrease of a missing edge skip the
// writes; same-node items and unknown opcodes go from dispatch straight to response;
// node removal writes the row and then the column entry of each node in turn; and a
// neighbor list reads, checks and decides each node, then gives the final result. A
// result that waits for transfer holds the response or list end state, and in a list
// the decide state once a second listed node is ready. The result register frees the
// input side: a new item is taken while the last result still waits for transfer.
module weighted_edge_table import wet_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	wet_req_if.sink   req,
	wet_rsp_if.source rsp
);

	ctl_cmd_t cmd;
	dp_stat_t stat;
	state_t   state;
	result_t  res;
	logic     rdy;

	wet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (rdy),
		.stat      (stat),
		.cmd       (cmd),
		.state     (state)
	);

	wet_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (req.opcode),
		.node_a       (req.node_a),
		.node_b       (req.node_b),
		.amount       (req.amount),
		.include_self (req.include_self),
		.rsp_ready    (rsp.ready),
		.out_valid    (rsp.valid),
		.out_res      (res)
	);

	assign req.ready          = rdy;
	assign rsp.status         = res.status;
	assign rsp.removed        = res.removed;
	assign rsp.exists         = res.exists;
	assign rsp.weight         = res.weight;
	assign rsp.neighbor       = res.neighbor;
	assign rsp.neighbor_valid = res.neighbor_valid;
	assign rsp.last           = res.last;

	// a result that is not the last of its item is always a listed node
	a_mid_is_list: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.last) |-> rsp.neighbor_valid)
		else $error("non-final result without a listed node");

	// no item taken during the clearing sweep
	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_CLR) |-> !req.ready)
		else $error("input ready during memory clear");

	// memory writes only from write states
	a_we_states: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_we |-> (state == S_CLR || state == S_WR1 || state == S_WR2 ||
			state == S_RM1 || state == S_RM2))
		else $error("memory write outside a write state");

endmodule

### sim/tb_top.sv
// Testbench for weighted_edge_table: directed table plus random traffic against a predictor.
`timescale 1ns / 1ps

module tb_top;
	import wet_pkg::*;

	logic clk;
	logic arst_n;

	wet_req_if req ();
	wet_rsp_if rsp ();

	weighted_edge_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	typedef struct {
		logic [2:0]             opcode;
		logic [NODE_W-1:0]      node_a;
		logic [NODE_W-1:0]      node_b;
		logic [WEIGHT_BITS-1:0] amount;
		logic                   include_self;
		logic                   has_exp;
		result_t                exp;
	} row_t;

	localparam logic [WEIGHT_BITS-1:0] W_MAX = '1;
	localparam logic [2:0] OP_BAD6 = 3'd6;
	localparam logic [2:0] OP_BAD7 = 3'd7;
	localparam int LIMIT = 2000000;

	// predictor state: symmetric table
	logic                   tbl_present [NODES][NODES];
	logic [WEIGHT_BITS-1:0] tbl_weight  [NODES][NODES];

	result_t pending_results [$];
	row_t    stim_q [$];

	int errors = 0;
	int cycles = 0;
	int n_items = 0;
	int n_results = 0;
	int stall_mode = 0; // 1: receiver holds off for a long stretch
	bit stim_done = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic result_t mk_res(logic [1:0] st, int rm, int ex, int w, int nb,
			int nv, int lst);
		result_t r;
		r.status = st; r.removed = 1'(rm); r.exists = 1'(ex); r.weight = WEIGHT_BITS'(w);
		r.neighbor = NODE_W'(nb); r.neighbor_valid = 1'(nv); r.last = 1'(lst);
		return r;
	endfunction

	// queue one expected result at the tail
	function automatic void add_expect(result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// queue one stimulus row at the tail
	function automatic void add_row(row_t r);
		stim_q.insert(stim_q.size(), r);
	endfunction

	function automatic void write_edge(int a, int b, int p, int w);
		tbl_present[a][b] = 1'(p); tbl_present[b][a] = 1'(p);
		tbl_weight[a][b] = WEIGHT_BITS'(w);  tbl_weight[b][a] = WEIGHT_BITS'(w);
	endfunction

	// compute the results of one item and update the table
	task automatic predict_edge_op(row_t it);
		int a, b, cnt;
		logic has;
		logic [WEIGHT_BITS:0] sum;
		a = it.node_a; b = it.node_b;
		has = tbl_present[a][b];
		if (it.opcode <= OP_SET && a == b) begin
			add_expect(mk_res(ST_SAME, 0, 0, 0, 0, 0, 1));
			return;
		end
		case (it.opcode)
			OP_INC: begin
				sum = has ? ({1'b0, tbl_weight[a][b]} + it.amount) : {1'b0, it.amount};
				write_edge(a, b, 1, sum[WEIGHT_BITS] ? W_MAX : sum[WEIGHT_BITS-1:0]);
				add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
			end
			OP_DEC: begin
				if (!has) begin
					add_expect(mk_res(ST_MISSING, 0, 0, 0, 0, 0, 1));
				end else if (tbl_weight[a][b] > ONE_WEIGHT) begin
					write_edge(a, b, 1, tbl_weight[a][b] - ONE_WEIGHT);
					add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
				end else begin
					write_edge(a, b, 0, 0);
					add_expect(mk_res(ST_OK, 1, 0, 0, 0, 0, 1));
				end
			end
			OP_QUERY: begin
				add_expect(mk_res(ST_OK, 0, has, has ? tbl_weight[a][b] : '0, 0, 0, 1));
			end
			OP_SET: begin
				write_edge(a, b, 1, it.amount);
				add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
			end
			OP_RMNODE: begin
				for (int n = 0; n < NODES; n++) write_edge(a, n, 0, 0);
				add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
			end
			OP_LIST: begin
				cnt = 0;
				for (int n = 0; n < NODES; n++) begin
					if (n == a) begin
						if (it.include_self) begin
							add_expect(mk_res(ST_OK, 0, 0, 0, n, 1, 0));
							cnt++;
						end
					end else if (tbl_present[a][n] && tbl_weight[a][n] >= it.amount) begin
						add_expect(mk_res(ST_OK, 0, 0, tbl_weight[a][n], n, 1, 0));
						cnt++;
					end
				end
				if (cnt == 0) add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
				else pending_results[$].last = 1'b1;
			end
			default: add_expect(mk_res(ST_OK, 0, 0, 0, 0, 0, 1));
		endcase
	endtask

	function automatic row_t mk_row(logic [2:0] op, int a, int b, int amt, logic s);
		row_t r;
		r.opcode = op; r.node_a = NODE_W'(a); r.node_b = NODE_W'(b);
		r.amount = WEIGHT_BITS'(amt);
		r.include_self = s; r.has_exp = 1'b0; r.exp = '0;
		return r;
	endfunction

	function automatic row_t with_exp(row_t r, result_t e);
		r.has_exp = 1'b1; r.exp = e;
		return r;
	endfunction

	// random item, mostly on a few hot nodes so edges build up
	function automatic row_t rand_row();
		int a, b, roll, amt;
		logic [2:0] op;
		roll = $urandom_range(0, 99);
		if (roll < 25) op = OP_INC;
		else if (roll < 45) op = OP_DEC;
		else if (roll < 62) op = OP_QUERY;
		else if (roll < 77) op = OP_SET;
		else if (roll < 82) op = OP_RMNODE;
		else if (roll < 96) op = OP_LIST;
		else op = 3'($urandom_range(6, 7));
		if ($urandom_range(0, 3) != 0) begin
			a = $urandom_range(0, 5); b = $urandom_range(0, 5);
		end else begin
			a = $urandom_range(0, 31); b = $urandom_range(0, 31);
		end
		roll = $urandom_range(0, 9);
		if (roll < 5) amt = $urandom_range(0, 1024);
		else if (roll < 8) amt = $urandom_range(0, 24'hFFFFFF);
		else if (roll == 8) amt = 24'hFFFFFF;
		else amt = 0;
		return mk_row(op, a, b, amt, 1'($urandom_range(0, 1)));
	endfunction

	// drive items with random gaps
	initial begin
		int gap;
		row_t it;
		req.valid = 1'b0; req.opcode = '0; req.node_a = '0; req.node_b = '0;
		req.amount = '0; req.include_self = 1'b0;
		arst_n = 1'b0;
		for (int a = 0; a < NODES; a++)
			for (int b = 0; b < NODES; b++) begin
				tbl_present[a][b] = 1'b0; tbl_weight[a][b] = '0;
			end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed table
		add_row(with_exp(mk_row(OP_QUERY, 0, 31, 0, 0), mk_res(ST_OK, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_DEC, 3, 4, 0, 0), mk_res(ST_MISSING, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_INC, 7, 7, 5, 0), mk_res(ST_SAME, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_SET, 9, 9, 5, 0), mk_res(ST_SAME, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_LIST, 2, 0, 0, 0), mk_res(ST_OK, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_LIST, 31, 0, 0, 1), mk_res(ST_OK, 0, 0, 0, 31, 1, 1)));
		add_row(mk_row(OP_SET, 0, 31, 24'hFFFFFF, 0));
		add_row(with_exp(mk_row(OP_QUERY, 31, 0, 0, 0),
			mk_res(ST_OK, 0, 1, 24'hFFFFFF, 0, 0, 1)));
		add_row(mk_row(OP_INC, 0, 31, 24'hFFFFFF, 0));
		add_row(with_exp(mk_row(OP_QUERY, 0, 31, 0, 0),
			mk_res(ST_OK, 0, 1, 24'hFFFFFF, 0, 0, 1)));
		add_row(mk_row(OP_SET, 1, 2, 0, 0));
		add_row(mk_row(OP_SET, 1, 3, 256, 0));
		add_row(mk_row(OP_SET, 1, 4, 257, 0));
		add_row(mk_row(OP_INC, 1, 5, 700, 0));
		add_row(mk_row(OP_LIST, 1, 0, 0, 1));
		add_row(mk_row(OP_LIST, 1, 0, 257, 0));
		add_row(with_exp(mk_row(OP_DEC, 2, 1, 0, 0), mk_res(ST_OK, 1, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_DEC, 1, 3, 0, 0), mk_res(ST_OK, 1, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_DEC, 4, 1, 0, 0), mk_res(ST_OK, 0, 0, 0, 0, 0, 1)));
		add_row(mk_row(OP_QUERY, 1, 4, 0, 0));
		add_row(mk_row(OP_RMNODE, 1, 0, 0, 0));
		add_row(mk_row(OP_LIST, 1, 0, 0, 0));
		add_row(with_exp(mk_row(OP_BAD6, 1, 2, 3, 1), mk_res(ST_OK, 0, 0, 0, 0, 0, 1)));
		add_row(with_exp(mk_row(OP_BAD7, 31, 31, 24'hFFFFFF, 1),
			mk_res(ST_OK, 0, 0, 0, 0, 0, 1)));

		// dense star so a list reaches all 32 results
		for (int n = 1; n < NODES; n++) add_row(mk_row(OP_INC, 0, n, n * 3, 0));
		add_row(mk_row(OP_LIST, 0, 0, 0, 1));
		for (int i = 0; i < 95; i++) add_row(rand_row());

		@(posedge clk);
		while (stim_q.size() > 0) begin
			it = stim_q.pop_front();
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			req.valid <= 1'b1; req.opcode <= it.opcode; req.node_a <= it.node_a;
			req.node_b <= it.node_b; req.amount <= it.amount;
			req.include_self <= it.include_self;
			@(posedge clk);
			while (!req.ready) @(posedge clk);
			// transfer happened at this edge
			predict_edge_op(it);
			if (it.has_exp && !(pending_results[$] === it.exp)) begin
				$error("directed row %0d: predictor disagrees with table", n_items);
				errors++;
			end
			n_items++;
		end
		req.valid <= 1'b0;
		stim_done = 1;
	end

	// receiver: random stalls, one long hold-off once the full list is in
	initial begin
		int hold;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			// 24 directed rows and 31 star edges come before the full list
			if (n_items >= 56 && stall_mode == 0) begin
				stall_mode = 1;
				rsp.ready <= 1'b0;
				hold = 0;
				while (hold < 400) begin
					@(posedge clk);
					hold++;
				end
				stall_mode = 2;
			end else if ($urandom_range(0, 19) == 0) begin
				rsp.ready <= 1'b0;
				repeat ($urandom_range(5, 40)) @(posedge clk);
				rsp.ready <= 1'b1;
			end else begin
				rsp.ready <= ($urandom_range(0, 3) != 0);
			end
		end
	end

	// compare each transfer against the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (arst_n && rsp.valid && rsp.ready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: nothing pending");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (rsp.status !== e.status) begin
					$error("status: expected %0d actual %0d", e.status, rsp.status); errors++;
				end
				if (rsp.removed !== e.removed) begin
					$error("removed: expected %0d actual %0d", e.removed, rsp.removed); errors++;
				end
				if (rsp.exists !== e.exists) begin
					$error("exists: expected %0d actual %0d", e.exists, rsp.exists); errors++;
				end
				if (rsp.weight !== e.weight) begin
					$error("weight: expected %0h actual %0h", e.weight, rsp.weight); errors++;
				end
				if (rsp.neighbor !== e.neighbor) begin
					$error("neighbor: expected %0d actual %0d", e.neighbor, rsp.neighbor); errors++;
				end
				if (rsp.neighbor_valid !== e.neighbor_valid) begin
					$error("neighbor_valid: expected %0d actual %0d", e.neighbor_valid,
						rsp.neighbor_valid); errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last: expected %0d actual %0d", e.last, rsp.last); errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (pending_results.size() != 0) errors++;
		$display("covered %0d items and %0d results over all six opcodes, saturation,",
			n_items, n_results);
		$display("same-node, missing edge, full lists and a long receiver hold-off");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
